// ----- sv/clp_pkg.sv -----
// ----------------------------------------------------------------------------
// clp_pkg
// shared types, outcode bits and helpers for the line clipper
// ----------------------------------------------------------------------------
package clp_pkg;

  localparam int CW        = 24;          // coordinate width, signed
  localparam int PW        = 2 * CW;      // product / dividend width
  localparam int DIV_STEPS = PW / 2;      // two quotient bits per cycle
  localparam int DIV_CW    = $clog2(DIV_STEPS);
  localparam int AW        = 4;           // config byte address width

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   diff_t;
  typedef logic        [CW-1:0] mag_t;
  typedef logic        [PW-1:0] prod_t;
  typedef logic        [3:0]    ocode_t;

  localparam ocode_t OC_LEFT   = 4'd1;
  localparam ocode_t OC_RIGHT  = 4'd2;
  localparam ocode_t OC_BOTTOM = 4'd4;
  localparam ocode_t OC_TOP    = 4'd8;

  // register indexes
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
  } window_t;

  function automatic ocode_t outcode(coord_t x, coord_t y, window_t w);
    ocode_t c;
    c = '0;
    if (x < w.left) c = c | OC_LEFT;
    else if (x > w.right) c = c | OC_RIGHT;
    if (y < w.bottom) c = c | OC_BOTTOM;
    else if (y > w.top) c = c | OC_TOP;
    return c;
  endfunction

  // magnitude of a difference; always below 2^CW
  function automatic mag_t mag(diff_t v);
    logic [CW:0] u;
    u = v[CW] ? (~v + 1'b1) : v;
    return u[CW-1:0];
  endfunction

endpackage

// ----- sv/clp_muldiv.sv -----
// ----------------------------------------------------------------------------
// clp_muldiv
// unsigned a*b/d: a product state, then radix-4 restoring division
// ----------------------------------------------------------------------------
module clp_muldiv (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  clp_pkg::mag_t a,
  input  clp_pkg::mag_t b,
  input  clp_pkg::mag_t d,
  output logic          done,
  output clp_pkg::prod_t q
);
  import clp_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  logic [1:0]        state_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              done_r;
  mag_t              a_r, b_r, d_r, rem_r;
  prod_t             dvd_r, q_r, prod;

  logic [CW:0] t0, t1, s0, s1;
  logic        b0, b1;
  mag_t        r1, r2;

  assign prod = a_r * b_r;

  always_comb begin
    t0 = {rem_r, dvd_r[PW-1]};
    s0 = t0 - {1'b0, d_r};
    b0 = (t0 >= {1'b0, d_r});
    r1 = b0 ? s0[CW-1:0] : t0[CW-1:0];
    t1 = {r1, dvd_r[PW-2]};
    s1 = t1 - {1'b0, d_r};
    b1 = (t1 >= {1'b0, d_r});
    r2 = b1 ? s1[CW-1:0] : t1[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= a;
            b_r     <= b;
            d_r     <= d;
            state_r <= M_MUL;
          end
        end
        M_MUL: begin
          dvd_r   <= prod;
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= M_DIV;
        end
        M_DIV: begin
          rem_r <= r2;
          dvd_r <= {dvd_r[PW-3:0], 2'b00};
          q_r   <= {q_r[PW-3:0], b0, b1};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= M_IDLE;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ----- sv/cohen_sutherland_line_clipper_top.sv -----
// ----------------------------------------------------------------------------
// cohen_sutherland_line_clipper_top
// clips one segment per beat against a register-held window (outcode method)
// ----------------------------------------------------------------------------
// sequence: a segment settled without clipping passes only the outcode, test
//   and done states; each edge clip (at most four) adds a divider pass
// throughput: one segment at a time; each clip is set by the shared
//   multiply/divide unit, which works on one intersection at a time
// reset: synchronous active-low rst_n clears the sequencer and the output
//   valid and loads the window with -1.0 .. +1.0 on both axes
module cohen_sutherland_line_clipper_top (
  input  logic                    clk,
  input  logic                    rst_n,
  // input segment beat
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [95:0]             in_tdata,   // start_x, start_y, end_x, end_y
  // result beat
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [95:0]             out_tdata,  // clip_start_x, clip_start_y,
                                              // clip_end_x, clip_end_y
  output logic [0:0]              out_tuser,  // visible
  // window registers
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [clp_pkg::AW-1:0]  cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import clp_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CODE1 = 3'd1;  // outcode of first endpoint
  localparam logic [2:0] S_CODE2 = 3'd2;  // outcode of second endpoint
  localparam logic [2:0] S_TEST  = 3'd3;  // accept / reject / pick an edge
  localparam logic [2:0] S_WAIT  = 3'd4;  // intersection in the divider
  localparam logic [2:0] S_FIN   = 3'd5;  // add, saturate, move the endpoint
  localparam logic [2:0] S_DONE  = 3'd6;  // hand the result to the output reg

  logic [2:0]  state_r, state_nxt;
  window_t     win_r;
  logic [95:0] in_r;                      // original segment for rejects
  coord_t      x1_r, y1_r, x2_r, y2_r;
  ocode_t      c1_r, c2_r;
  logic        both_r;                    // first pass codes both endpoints
  logic [2:0]  step_r;                    // clips made so far
  logic        vis_r;
  logic        ybnd_r, move1_r, neg_r;
  coord_t      bnd_r, a1_r;
  logic        out_tvalid_r;
  logic [95:0] out_tdata_r;
  logic        out_tuser_r;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LEFT:   cfg_prdata = 32'(win_r.left);
      REG_RIGHT:  cfg_prdata = 32'(win_r.right);
      REG_BOTTOM: cfg_prdata = 32'(win_r.bottom);
      REG_TOP:    cfg_prdata = 32'(win_r.top);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outcode unit, shared by both endpoints
  // ---------------------------------------------------------------------------
  ocode_t oc_v;
  assign oc_v = (state_r == S_CODE1) ? outcode(x1_r, y1_r, win_r)
                                     : outcode(x2_r, y2_r, win_r);

  // ---------------------------------------------------------------------------
  // edge selection and intersection operands
  // ---------------------------------------------------------------------------
  ocode_t c_sel;
  logic   ybnd_v, trivial_in, trivial_out, den_zero, clip_go;
  coord_t bnd_v;
  diff_t  dx, dy, ex, ey, num1, num2, den;

  always_comb begin
    c_sel  = (c1_r != '0) ? c1_r : c2_r;
    ybnd_v = ((c_sel & (OC_TOP | OC_BOTTOM)) != '0);
    if (ybnd_v) bnd_v = ((c_sel & OC_TOP) != '0) ? win_r.top : win_r.bottom;
    else        bnd_v = ((c_sel & OC_RIGHT) != '0) ? win_r.right : win_r.left;
    dx = {x2_r[CW-1], x2_r} - {x1_r[CW-1], x1_r};
    dy = {y2_r[CW-1], y2_r} - {y1_r[CW-1], y1_r};
    ex = {bnd_v[CW-1], bnd_v} - {x1_r[CW-1], x1_r};
    ey = {bnd_v[CW-1], bnd_v} - {y1_r[CW-1], y1_r};
    // horizontal edge: new x from x1; vertical edge: new y from y1
    num1 = ybnd_v ? dx : dy;
    num2 = ybnd_v ? ey : ex;
    den  = ybnd_v ? dy : dx;
    trivial_in  = ((c1_r | c2_r) == '0);
    trivial_out = ((c1_r & c2_r) != '0) || (step_r == 3'd4);
    den_zero    = (den == '0);
    clip_go     = (state_r == S_TEST) && !trivial_in && !trivial_out && !den_zero;
  end

  // ---------------------------------------------------------------------------
  // shared multiply / divide unit
  // ---------------------------------------------------------------------------
  logic  md_done;
  prod_t md_q;

  clp_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (clip_go),
    .a     (mag(num1)),
    .b     (mag(num2)),
    .d     (mag(den)),
    .done  (md_done),
    .q     (md_q)
  );

  // base coordinate plus or minus the quotient, saturated to CW bits
  logic signed [PW+1:0] a1_ext, q_ext, sum;
  coord_t               sat_v;

  always_comb begin
    a1_ext = {{(PW+2-CW){a1_r[CW-1]}}, a1_r};
    q_ext  = {2'b00, md_q};
    sum    = neg_r ? (a1_ext - q_ext) : (a1_ext + q_ext);
    if ((&sum[PW+1:CW-1]) || !(|sum[PW+1:CW-1])) sat_v = sum[CW-1:0];
    else if (sum[PW+1])                        sat_v = {1'b1, {(CW-1){1'b0}}};
    else                                       sat_v = {1'b0, {(CW-1){1'b1}}};
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic in_acc, out_free;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CODE1;
      S_CODE1: state_nxt = both_r ? S_CODE2 : S_TEST;
      S_CODE2: state_nxt = S_TEST;
      S_TEST: begin
        if (trivial_in || trivial_out || den_zero) state_nxt = S_DONE;
        else                                       state_nxt = S_WAIT;
      end
      S_WAIT:  if (md_done) state_nxt = S_FIN;
      S_FIN:   state_nxt = move1_r ? S_CODE1 : S_CODE2;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      both_r       <= 1'b0;
      step_r       <= '0;
      vis_r        <= 1'b0;
      win_r.left   <= -coord_t'(4096);
      win_r.right  <= coord_t'(4096);
      win_r.bottom <= -coord_t'(4096);
      win_r.top    <= coord_t'(4096);
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_LEFT:   win_r.left   <= cfg_pwdata[CW-1:0];
          REG_RIGHT:  win_r.right  <= cfg_pwdata[CW-1:0];
          REG_BOTTOM: win_r.bottom <= cfg_pwdata[CW-1:0];
          REG_TOP:    win_r.top    <= cfg_pwdata[CW-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            in_r   <= in_tdata;
            x1_r   <= in_tdata[23:0];
            y1_r   <= in_tdata[47:24];
            x2_r   <= in_tdata[71:48];
            y2_r   <= in_tdata[95:72];
            both_r <= 1'b1;
            step_r <= '0;
          end
        end
        S_CODE1: c1_r <= oc_v;
        S_CODE2: c2_r <= oc_v;
        S_TEST: begin
          vis_r   <= trivial_in;
          ybnd_r  <= ybnd_v;
          move1_r <= (c1_r != '0);
          bnd_r   <= bnd_v;
          a1_r    <= ybnd_v ? x1_r : y1_r;
          neg_r   <= num1[CW] ^ num2[CW] ^ den[CW];
        end
        S_FIN: begin
          both_r <= 1'b0;
          step_r <= step_r + 1'b1;
          if (move1_r) begin
            x1_r <= ybnd_r ? sat_v : bnd_r;
            y1_r <= ybnd_r ? bnd_r : sat_v;
          end else begin
            x2_r <= ybnd_r ? sat_v : bnd_r;
            y2_r <= ybnd_r ? bnd_r : sat_v;
          end
        end
        default: ;
      endcase

      // output register: a finished beat waits here while the next segment runs
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
        out_tuser_r  <= vis_r;
        out_tdata_r  <= vis_r ? {y2_r, x2_r, y1_r, x1_r} : in_r;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule

// ----- verif/cohen_sutherland_line_clipper_top_tb.sv -----
// ----------------------------------------------------------------------------
// cohen_sutherland_line_clipper_top_tb
// self-checking bench for the outcode line clipper: segment beats go in under
// several window settings, a scoreboard predicts every clipped result and
// compares each result beat with it field by field
// ----------------------------------------------------------------------------
module cohen_sutherland_line_clipper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clp_pkg::*;

  localparam longint CMAX      = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint CMIN      = -CMAX - 1;
  localparam int     SETTLE    = 150;       // cycles past the last result beat
  localparam int     LIMIT     = 1500000;   // watchdog, in clock cycles
  localparam int     PER_PHASE = 335;       // random segments per window setting

  // tdata layout: start_x lowest, end_y highest
  typedef struct packed {
    coord_t ey;
    coord_t ex;
    coord_t sy;
    coord_t sx;
  } segment_t;

  typedef struct packed {
    logic     visible;
    segment_t pts;
  } clip_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the window, clip predictor, queue of pending results
  // --------------------------------------------------------------------------
  class clip_scoreboard;
    window_t      win;
    clip_result_t expected_q[$];
    int unsigned  errors;

    function new();
      win.left   = -coord_t'(4096);
      win.right  = coord_t'(4096);
      win.bottom = -coord_t'(4096);
      win.top    = coord_t'(4096);
      errors     = 0;
    endfunction

    function longint wide(coord_t v);
      return v;
    endfunction

    function longint saturate(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
    endfunction

    function ocode_t region_of(longint x, longint y);
      ocode_t c;
      c = '0;
      if (x < wide(win.left)) c = c | OC_LEFT;
      else if (x > wide(win.right)) c = c | OC_RIGHT;
      if (y < wide(win.bottom)) c = c | OC_BOTTOM;
      else if (y > wide(win.top)) c = c | OC_TOP;
      return c;
    endfunction

    // a1 + num1 * num2 / den, quotient truncated toward zero; product stays
    // below 2^48 so the longint arithmetic never overflows
    function longint cross_point(longint a1, longint num1, longint num2, longint den);
      return saturate(a1 + (num1 * num2) / den);
    endfunction

    function clip_result_t clip_segment(segment_t s);
      longint       x1, y1, x2, y2, x, y;
      ocode_t       c1, c2, c;
      logic         in_window;
      int           pass_no;
      clip_result_t r;
      x1 = wide(s.sx);
      y1 = wide(s.sy);
      x2 = wide(s.ex);
      y2 = wide(s.ey);
      c1 = region_of(x1, y1);
      c2 = region_of(x2, y2);
      in_window = 1'b0;
      for (pass_no = 0; pass_no <= 4; pass_no++) begin
        if ((c1 | c2) == '0) begin
          in_window = 1'b1;
          break;
        end
        // trivially outside, or still unsettled after four clips
        if ((c1 & c2) != '0 || pass_no == 4) break;
        c = (c1 != '0) ? c1 : c2;
        if ((c & (OC_TOP | OC_BOTTOM)) != '0) begin
          y = ((c & OC_TOP) != '0) ? wide(win.top) : wide(win.bottom);
          if (y2 == y1) break;
          x = cross_point(x1, x2 - x1, y - y1, y2 - y1);
        end else begin
          x = ((c & OC_RIGHT) != '0) ? wide(win.right) : wide(win.left);
          if (x2 == x1) break;
          y = cross_point(y1, y2 - y1, x - x1, x2 - x1);
        end
        if (c1 != '0) begin
          x1 = x;
          y1 = y;
          c1 = region_of(x1, y1);
        end else begin
          x2 = x;
          y2 = y;
          c2 = region_of(x2, y2);
        end
      end
      r.visible = in_window;
      r.pts     = s;
      // a rejected segment comes back untouched
      if (in_window) begin
        r.pts.sx = coord_t'(x1);
        r.pts.sy = coord_t'(y1);
        r.pts.ex = coord_t'(x2);
        r.pts.ey = coord_t'(y2);
      end
      return r;
    endfunction

    function void note_segment(segment_t s);
      expected_q.insert(expected_q.size(), clip_segment(s));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_coord(string name, coord_t got, coord_t want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(clip_result_t got);
      clip_result_t want;
      if (expected_q.size() == 0) begin
        report("result beat with no segment pending");
        return;
      end
      want = expected_q.pop_front();
      if (got.visible !== want.visible)
        report($sformatf("visible got %0b want %0b", got.visible, want.visible));
      compare_coord("clip_start_x", got.pts.sx, want.pts.sx);
      compare_coord("clip_start_y", got.pts.sy, want.pts.sy);
      compare_coord("clip_end_x", got.pts.ex, want.pts.ex);
      compare_coord("clip_end_y", got.pts.ey, want.pts.ey);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [95:0]   in_tdata;     // start_x, start_y, end_x, end_y
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [95:0]   out_tdata;    // clip_start_x, clip_start_y, clip_end_x, clip_end_y
  logic [0:0]    out_tuser;    // visible
  logic          cfg_psel;
  logic          cfg_penable;
  logic          cfg_pwrite;
  logic [AW-1:0] cfg_paddr;
  logic [31:0]   cfg_pwdata;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  clip_scoreboard sb = new();

  int in_idle_pct  = 28;   // chance per cycle that the sender holds off
  int out_idle_pct = 46;   // chance per cycle that the receiver stalls
  int cycles       = 0;

  cohen_sutherland_line_clipper_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // watchdog and result checking, both on the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      sb.check_result('{visible: out_tuser[0], pts: out_tdata});
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one register write: setup phase, access phase, then a quiet phase
  task automatic write_window_reg(logic [1:0] idx, coord_t v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(32 - CW){v[CW-1]}}, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_LEFT:   sb.win.left   = v;
      REG_RIGHT:  sb.win.right  = v;
      REG_BOTTOM: sb.win.bottom = v;
      REG_TOP:    sb.win.top    = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // registers change only once the block has handed back every result
  task automatic set_window(coord_t l, coord_t r, coord_t b, coord_t t);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_window_reg(REG_LEFT, l);
    write_window_reg(REG_RIGHT, r);
    write_window_reg(REG_BOTTOM, b);
    write_window_reg(REG_TOP, t);
  endtask

  // called at a falling edge; valid stays high afterwards for a following beat
  task automatic send_segment(segment_t s);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    sb.note_segment(s);
    @(negedge clk);
  endtask

  function automatic segment_t seg(longint sx, longint sy, longint ex, longint ey);
    segment_t s;
    s.sx = coord_t'(sx);
    s.sy = coord_t'(sy);
    s.ex = coord_t'(ex);
    s.ey = coord_t'(ey);
    return s;
  endfunction

  // mostly around the window on this axis, sometimes anywhere, at the range
  // ends or exactly on an edge
  function automatic coord_t near_coord(coord_t e0, coord_t e1);
    longint lo, hi, span, v;
    lo   = (e0 < e1) ? e0 : e1;
    hi   = (e0 < e1) ? e1 : e0;
    span = hi - lo + 64;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = lo - span + longint'($urandom_range(0, 32'(3 * span)));
      6, 7:             v = coord_t'($urandom);
      8:                v = $urandom_range(0, 1) ? CMAX : CMIN;
      default:          v = $urandom_range(0, 1) ? e0 : e1;
    endcase
    return coord_t'(sb.saturate(v));
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    s.sx = near_coord(sb.win.left, sb.win.right);
    s.sy = near_coord(sb.win.bottom, sb.win.top);
    s.ex = near_coord(sb.win.left, sb.win.right);
    s.ey = near_coord(sb.win.bottom, sb.win.top);
    // some horizontal, vertical and single-point segments
    case ($urandom_range(0, 19))
      0: s.ey = s.sy;
      1: s.ex = s.sx;
      2: begin
        s.ex = s.sx;
        s.ey = s.sy;
      end
      default: ;
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int     phase;
    coord_t a, b, c, d;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed, window as left by reset (-1.0 .. +1.0 on both axes)
    send_segment(seg(0, 0, 2048, -2048));              // wholly inside
    send_segment(seg(-8192, 8192, 8192, 12288));       // both above
    send_segment(seg(-8192, -100, -5000, 100));        // both left
    send_segment(seg(100, -9000, 3000, -5000));        // both below
    send_segment(seg(9000, 0, 5000, 3000));            // both right
    send_segment(seg(0, 0, 1000, 8192));               // leaves through top
    send_segment(seg(1000, 0, 3000, -9000));           // leaves through bottom
    send_segment(seg(0, 1000, 9000, 2000));            // leaves through right
    send_segment(seg(0, -1000, -9000, 2000));          // leaves through left
    send_segment(seg(-8192, -8192, 8192, 8192));       // both ends moved
    send_segment(seg(-8192, 1000, 1000, 8192));        // misses the corner
    send_segment(seg(-4096, 4096, 4096, -4096));       // ends on the corners
    send_segment(seg(0, 0, -9000, -7));                // negative quotient
    send_segment(seg(CMIN, CMIN, CMAX, CMAX));
    send_segment(seg(CMAX, CMIN, CMIN, CMAX));
    send_segment(seg(CMIN, CMAX, CMIN, CMAX));         // point, outside
    send_segment(seg(0, 0, 0, 0));                     // point, inside
    send_segment(seg(5592405, -5592406, -5592406, 5592405));

    // directed, inverted window on both axes
    set_window(4096, -4096, 4096, -4096);
    send_segment(seg(0, 0, 8192, 8192));
    send_segment(seg(-8192, 1, 8192, -1));
    send_segment(seg(CMIN, CMAX, CMAX, CMIN));
    send_segment(seg(5000, -5000, -5000, 5000));

    // random phases: receiver stalls more first, then sender, then neither
    for (phase = 0; phase < 6; phase++) begin
      in_idle_pct  = (phase < 2) ? 28 : (phase < 4) ? 46 : 0;
      out_idle_pct = (phase < 2) ? 46 : (phase < 4) ? 28 : 0;
      a = coord_t'($urandom);
      b = coord_t'($urandom);
      c = coord_t'($urandom);
      d = coord_t'($urandom);
      case (phase)
        // small window somewhere in the plane
        0: set_window(a >>> 2, (a >>> 2) + coord_t'($urandom_range(1, 65536)),
                      b >>> 2, (b >>> 2) + coord_t'($urandom_range(1, 65536)));
        // whole coordinate range
        1: set_window(coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMAX));
        // inverted on both axes
        2: set_window((a > b) ? a : b, (a > b) ? b : a, (c > d) ? c : d, (c > d) ? d : c);
        // window shrunk to a single point
        3: set_window(a >>> 8, a >>> 8, b >>> 8, b >>> 8);
        // wide, well-formed
        4: set_window((a < b) ? a : b, (a < b) ? b : a, (c < d) ? c : d, (c < d) ? d : c);
        // anything, often inverted on one axis
        default: set_window(a, b, c, d);
      endcase
      repeat (PER_PHASE) send_segment(random_segment());
    end

    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- cohen_sutherland_line_clipper_top.f -----
sv/clp_pkg.sv
sv/clp_muldiv.sv
sv/cohen_sutherland_line_clipper_top.sv
verif/cohen_sutherland_line_clipper_top_tb.sv
